[design/sstag_pkg.sv]
// sstag_pkg: types and constants shared by the sparse shadow tag store
// no dependencies

package sstag_pkg;

    localparam int MAX_PAGES      = 16;
    localparam int MAX_RANGE      = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam int WORDS_PER_PAGE = PAGE_BYTES / 8;
    localparam int SLOT_W         = $clog2(MAX_PAGES);
    localparam int WORD_W         = $clog2(WORDS_PER_PAGE);
    localparam int MEM_AW         = SLOT_W + WORD_W;
    localparam int MEM_DEPTH      = MAX_PAGES * WORDS_PER_PAGE;
    localparam int PN_W           = 64 - $clog2(PAGE_BYTES);

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_OR    = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_UNIT_BITS = 2'd0,
        REG_GRAN      = 2'd1,
        REG_INITIAL   = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MOD,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } t_dir_res;

endpackage

[design/sstag_ifs.sv]
// sstag_ifs: item, result and configuration channel interfaces
// depends on nothing

interface sstag_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] address;
    logic [63:0] value;
    logic [6:0]  unit_count;
    modport source (output valid, mode, address, value, unit_count, input ready);
    modport sink (input valid, mode, address, value, unit_count, output ready);
endinterface

interface sstag_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_value;
    logic        page_present;
    logic        pool_full;
    modport source (output valid, read_value, page_present, pool_full, input ready);
    modport sink (input valid, read_value, page_present, pool_full, output ready);
endinterface

interface sstag_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/sparse_shadow_tag_store_unit.sv]
// sparse_shadow_tag_store_unit: top level, sequencer and tag datapath
// depends on sstag_pkg, sstag_ifs, sstag_dir and sstag_mem
//
// usage
// i_in carries one item: mode, address, value, unit_count; o_out returns
// one result item per input item; i_cfg writes unit_bits_log2 (0),
// gran_log2 (1) and initial_value (2) and is always ready; the user
// must write it only while idle, as the block does not enforce this.
// the block takes one item at a time; i_in.ready is high only when idle.
// query, read of an absent page: lookup, then result; present-page read:
// lookup, registered word read, then result. write and or: a unit that
// finds its page takes a lookup and a read-modify-write of its word via
// the memory's read and write ports; a skipped or dropped unit takes only
// its lookup; an allocating unit first fills the page's 512 words with
// initial_value, one word per cycle through the write port, then looks up
// again; a zero-length write or or range goes straight to the result.
// reset clears the page directory, state, configuration and r_ov; no
// clearing pass of word memory is needed; pages are filled on allocation.
// a result waits in the output register while o_out.ready is low; the
// block then holds the next finished result until the register frees.

module sparse_shadow_tag_store_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sstag_in_if.sink    i_in,
    sstag_out_if.source o_out,
    sstag_cfg_if.sink   i_cfg
);
    import sstag_pkg::*;

    t_state r_state, n_state;

    logic [2:0]  r_ub_cfg;
    logic [3:0]  r_gl_cfg;
    logic [63:0] r_init;

    logic [2:0]        r_ub;
    logic [3:0]        r_gl;
    logic [63:0]       r_mask;
    t_mode             r_mode;
    logic [63:0]       r_addr;
    logic [63:0]       r_val;
    logic [6:0]        r_left;
    logic [SLOT_W-1:0] r_slot;
    logic [5:0]        r_sh;
    logic [WORD_W-1:0] r_fcnt;
    logic [63:0]       r_rd;
    logic              r_pres;
    logic              r_full;
    logic              r_ov;
    logic [63:0]       r_ord;
    logic              r_opres;
    logic              r_ofull;

    t_dir_res          dir_res;
    logic              alloc;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [63:0]       mem_wdata;
    logic [MEM_AW-1:0] mem_raddr;
    logic [63:0]       mem_rdata;

    logic [2:0]  ub_e;
    logic [3:0]  gl_e;
    logic [3:0]  gl_lim;
    logic [6:0]  cnt_e;
    logic [14:0] span_mask;
    logic [14:0] bp;
    logic [63:0] init_m;
    logic [63:0] miss_v;
    logic [63:0] old_tag;
    logic [63:0] new_tag;
    logic        in_acc;
    logic        out_load;
    logic        unit_next;

    sstag_dir u_dir (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pn         (r_addr[63:64-PN_W]),
        .i_alloc      (alloc),
        .i_alloc_slot (dir_res.free_slot),
        .o_res        (dir_res)
    );

    sstag_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;

    assign o_out.valid        = r_ov;
    assign o_out.read_value   = r_ord;
    assign o_out.page_present = r_opres;
    assign o_out.pool_full    = r_ofull;

    // effective configuration at accept
    always_comb begin
        ub_e   = (r_ub_cfg > 3'd6) ? 3'd6 : r_ub_cfg;
        gl_lim = 4'd15 - {1'b0, ub_e};
        gl_e   = (r_gl_cfg > gl_lim) ? gl_lim : r_gl_cfg;
        cnt_e  = (i_in.unit_count > 7'(MAX_RANGE)) ? 7'(MAX_RANGE) : i_in.unit_count;
    end

    // tag position within the page
    always_comb begin
        span_mask = 15'h7fff >> r_ub;
        bp        = ((r_addr[14:0] & span_mask) >> r_gl) << r_ub;
        init_m    = r_init & r_mask;
        miss_v    = ((r_mode == MODE_OR) ? (r_init | r_val) : r_val) & r_mask;
        old_tag   = (mem_rdata >> r_sh) & r_mask;
        new_tag   = ((r_mode == MODE_OR) ? (old_tag | r_val) : r_val) & r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        alloc     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = {r_slot, bp[14:6]};
        mem_wdata = (mem_rdata & ~(r_mask << r_sh)) | (new_tag << r_sh);
        mem_raddr = {dir_res.hit_slot, bp[14:6]};
        unit_next = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ((t_mode'(i_in.mode) == MODE_WRITE || t_mode'(i_in.mode) == MODE_OR)
                            && cnt_e == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (r_mode == MODE_QUERY) begin
                    n_state = S_DONE;
                end else if (dir_res.hit) begin
                    n_state = S_MOD;
                end else if (r_mode == MODE_READ) begin
                    n_state = S_DONE;
                end else if (miss_v != init_m && dir_res.free) begin
                    alloc   = 1'b1;
                    n_state = S_FILL;
                end else begin
                    unit_next = 1'b1;
                    n_state   = (r_left == 7'd1) ? S_DONE : S_LOOK;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = {r_slot, r_fcnt};
                mem_wdata = r_init;
                if (r_fcnt == WORD_W'(WORDS_PER_PAGE - 1)) begin
                    n_state = S_LOOK;
                end
            end
            S_MOD: begin
                if (r_mode == MODE_READ) begin
                    n_state = S_DONE;
                end else begin
                    mem_we    = 1'b1;
                    unit_next = 1'b1;
                    n_state   = (r_left == 7'd1) ? S_DONE : S_LOOK;
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ub_cfg <= '0;
            r_gl_cfg <= '0;
            r_init   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_UNIT_BITS: r_ub_cfg <= i_cfg.data[2:0];
                    REG_GRAN:      r_gl_cfg <= i_cfg.data[3:0];
                    REG_INITIAL:   r_init   <= i_cfg.data;
                    REG_NONE:      ;
                    default:       ;
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ub   <= ub_e;
            r_gl   <= gl_e;
            r_mask <= (ub_e == 3'd6) ? '1 : ((64'd1 << (7'd1 << ub_e)) - 64'd1);
            r_mode <= t_mode'(i_in.mode);
            r_addr <= i_in.address;
            r_val  <= i_in.value;
            r_left <= cnt_e;
            r_rd   <= '0;
            r_pres <= 1'b0;
            r_full <= 1'b0;
        end
        if (r_state == S_LOOK) begin
            r_sh <= bp[5:0];
            if (r_mode == MODE_QUERY) begin
                r_pres <= dir_res.hit;
            end else if (dir_res.hit) begin
                r_slot <= dir_res.hit_slot;
            end else if (r_mode == MODE_READ) begin
                r_rd <= init_m;
            end else if (miss_v != init_m) begin
                if (dir_res.free) begin
                    r_slot <= dir_res.free_slot;
                    r_fcnt <= '0;
                end else begin
                    r_full <= 1'b1;
                end
            end
        end
        if (r_state == S_FILL) begin
            r_fcnt <= r_fcnt + 1'b1;
        end
        if (r_state == S_MOD && r_mode == MODE_READ) begin
            r_rd <= old_tag;
        end
        if (unit_next) begin
            r_addr <= r_addr + (64'd1 << r_gl);
            r_left <= r_left - 7'd1;
        end
        if (out_load) begin
            r_ord   <= r_rd;
            r_opres <= r_pres;
            r_ofull <= r_full;
        end
    end

endmodule

[design/sstag_mem.sv]
// sstag_mem: tag word storage, one write and one registered read port
// depends on sstag_pkg

module sstag_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [sstag_pkg::MEM_AW-1:0] i_waddr,
    input  logic [63:0]                 i_wdata,
    input  logic [sstag_pkg::MEM_AW-1:0] i_raddr,
    output logic [63:0]                 o_rdata
);
    import sstag_pkg::*;

    logic [63:0] r_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/sstag_dir.sv]
// sstag_dir: page directory, valid bits and page numbers, lookup and allocation
// depends on sstag_pkg

module sstag_dir (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sstag_pkg::PN_W-1:0]   i_pn,
    input  logic                        i_alloc,
    input  logic [sstag_pkg::SLOT_W-1:0] i_alloc_slot,
    output sstag_pkg::t_dir_res         o_res
);
    import sstag_pkg::*;

    logic [MAX_PAGES-1:0] r_valid;
    logic [PN_W-1:0]      r_pn [MAX_PAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_alloc) begin
            r_valid[i_alloc_slot] <= 1'b1;
        end
        if (i_alloc) begin
            r_pn[i_alloc_slot] <= i_pn;
        end
    end

    always_comb begin
        o_res = '0;
        for (int k = MAX_PAGES - 1; k >= 0; k--) begin
            if (r_valid[k] && r_pn[k] == i_pn) begin
                o_res.hit      = 1'b1;
                o_res.hit_slot = SLOT_W'(k);
            end
            if (!r_valid[k]) begin
                o_res.free      = 1'b1;
                o_res.free_slot = SLOT_W'(k);
            end
        end
    end

endmodule

[design/sstag_chk.sv]
// sstag_chk: port-level checks of the sparse shadow tag store
// bound to sparse_shadow_tag_store_unit; depends on its interface ports

module sstag_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_read_value,
    input logic        i_page_present,
    input logic        i_pool_full
);

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("new item taken while one is in work");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_page_present && (i_pool_full || i_read_value != 64'd0)))
        else $error("query result mixed with other fields");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sparse_shadow_tag_store_unit sstag_chk u_sstag_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_read_value   (o_out.read_value),
    .i_page_present (o_out.page_present),
    .i_pool_full    (o_out.pool_full)
);
